[rtl/core/fotb_pkg.sv]
// Shared types and constants of the FASTA one-hot bitplane parser.
package fotb_pkg;

    localparam int PLANE_BITS  = 64;
    localparam int POS_BITS    = 40;
    localparam int PLANE_COUNT = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_HEADER    = 8'h3E;
    localparam logic [7:0] CHAR_COMMENT   = 8'h3B;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;

    typedef enum logic [2:0] {
        KIND_RECORD = 3'd0,
        KIND_NAME   = 3'd1,
        KIND_PLANE  = 3'd2,
        KIND_ERROR  = 3'd3,
        KIND_TOTAL  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        MODE_START   = 3'd0,
        MODE_NAME    = 3'd1,
        MODE_HREST   = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_SEQ     = 3'd4,
        MODE_SKIP    = 3'd5
    } line_mode_t;

    // One queued job: a result, and optionally the total that follows it.
    typedef struct packed {
        kind_t                                 kind;
        logic [POS_BITS-1:0]                   position;
        logic [7:0]                            name_byte;
        logic [PLANE_COUNT-1:0][PLANE_BITS-1:0] planes;
        logic                                  has_total;
        logic [POS_BITS-1:0]                   total_pos;
    } job_t;

    // One result item as shown on the output channel.
    typedef struct packed {
        kind_t                                 kind;
        logic [POS_BITS-1:0]                   position;
        logic [7:0]                            name_byte;
        logic [PLANE_COUNT-1:0][PLANE_BITS-1:0] planes;
        logic                                  last;
    } result_t;

endpackage

[rtl/core/fotb_front.sv]
// Front end: classifies each text byte, tracks line and base state, and queues jobs.
module fotb_front #(
    parameter int WORD_BASES = 64,
    parameter int COUNT_BITS = 40
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      text_byte,
    input  logic            end_of_file,
    output logic            push,
    output fotb_pkg::job_t  job
);

    localparam int BIT_W = $clog2(WORD_BASES);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(WORD_BASES - 1);
    localparam int NP = fotb_pkg::PLANE_COUNT;
    localparam int PB = fotb_pkg::PLANE_BITS;
    localparam int PW = fotb_pkg::POS_BITS;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_NAME,
        ACT_HEADER,
        ACT_BASE,
        ACT_EOF
    } act_t;

    fotb_pkg::line_mode_t mode_reg, mode_next, mode_dec;
    logic record_open_reg, record_open_next;
    logic error_reg, error_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] word_idx_reg, word_idx_next;
    logic [BIT_W-1:0] bit_idx_reg, bit_idx_next;
    logic [NP-1:0][WORD_BASES-1:0] plane_reg, plane_next;

    act_t act;
    logic [NP-1:0] base_mask;
    logic base_bad;
    logic take_err;
    logic word_done;
    logic [WORD_BASES-1:0] set_vec;
    logic [NP-1:0][WORD_BASES-1:0] plane_upd;
    logic [NP-1:0][PB-1:0] plane_upd_ext, plane_reg_ext;
    logic [COUNT_BITS+PW-1:0] count_wide, word_idx_wide;
    logic [PW-1:0] count_pos, word_pos;

    // Base decode: bit 0 A, bit 1 C, bit 2 G, bit 3 T; N is valid with no bit.
    always_comb
    begin
        base_mask = '0;
        base_bad  = 1'b0;
        case (text_byte) inside
            8'h41, 8'h61: base_mask = 4'b0001;
            8'h43, 8'h63: base_mask = 4'b0010;
            8'h47, 8'h67: base_mask = 4'b0100;
            8'h54, 8'h74: base_mask = 4'b1000;
            8'h4E, 8'h6E: base_mask = 4'b0000;
            default:      base_bad  = 1'b1;
        endcase
    end

    assign take_err  = base_bad | (&count_reg);
    assign word_done = (bit_idx_reg == LAST_BIT);
    assign set_vec   = {{(WORD_BASES-1){1'b0}}, 1'b1} << bit_idx_reg;

    assign count_wide    = {{PW{1'b0}}, count_reg};
    assign word_idx_wide = {{PW{1'b0}}, word_idx_reg};
    assign count_pos     = count_wide[PW-1:0];
    assign word_pos      = word_idx_wide[PW-1:0];

    for (genvar k = 0; k < NP; k++) begin : g_plane
        logic [WORD_BASES+PB-1:0] upd_wide, reg_wide;
        assign plane_upd[k]     = plane_reg[k] | (base_mask[k] ? set_vec : '0);
        assign upd_wide         = {{PB{1'b0}}, plane_upd[k]};
        assign reg_wide         = {{PB{1'b0}}, plane_reg[k]};
        assign plane_upd_ext[k] = upd_wide[PB-1:0];
        assign plane_reg_ext[k] = reg_wide[PB-1:0];
    end

    // Line classification.
    always_comb
    begin
        act      = ACT_NONE;
        mode_dec = mode_reg;
        if (end_of_file)
        begin
            act = ACT_EOF;
        end
        else if (!error_reg)
        begin
            if (text_byte == fotb_pkg::CHAR_NEWLINE)
            begin
                mode_dec = fotb_pkg::MODE_START;
            end
            else
            begin
                unique case (mode_reg) inside
                    fotb_pkg::MODE_NAME:
                    begin
                        if (text_byte == fotb_pkg::CHAR_SPACE || text_byte == fotb_pkg::CHAR_TAB)
                            mode_dec = fotb_pkg::MODE_HREST;
                        else
                            act = ACT_NAME;
                    end
                    fotb_pkg::MODE_HREST, fotb_pkg::MODE_COMMENT, fotb_pkg::MODE_SKIP:
                    begin
                        act = ACT_NONE;
                    end
                    fotb_pkg::MODE_SEQ:
                    begin
                        act = ACT_BASE;
                    end
                    default:
                    begin
                        if (text_byte == fotb_pkg::CHAR_COMMENT)
                        begin
                            mode_dec = fotb_pkg::MODE_COMMENT;
                        end
                        else if (text_byte == fotb_pkg::CHAR_HEADER)
                        begin
                            mode_dec = fotb_pkg::MODE_NAME;
                            act      = ACT_HEADER;
                        end
                        else if (record_open_reg)
                        begin
                            mode_dec = fotb_pkg::MODE_SEQ;
                            act      = ACT_BASE;
                        end
                        else
                        begin
                            mode_dec = fotb_pkg::MODE_SKIP;
                        end
                    end
                endcase
            end
        end
    end

    // Next state.
    always_comb
    begin
        mode_next        = mode_reg;
        record_open_next = record_open_reg;
        error_next       = error_reg;
        count_next       = count_reg;
        word_idx_next    = word_idx_reg;
        bit_idx_next     = bit_idx_reg;
        plane_next       = plane_reg;
        if (accept)
        begin
            mode_next = mode_dec;
            case (act)
                ACT_EOF:
                begin
                    mode_next        = fotb_pkg::MODE_START;
                    record_open_next = 1'b0;
                    error_next       = 1'b0;
                    count_next       = '0;
                    word_idx_next    = '0;
                    bit_idx_next     = '0;
                    plane_next       = '0;
                end
                ACT_HEADER:
                begin
                    record_open_next = 1'b1;
                end
                ACT_BASE:
                begin
                    if (take_err)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_BITS'(1);
                        if (word_done)
                        begin
                            plane_next    = '0;
                            bit_idx_next  = '0;
                            word_idx_next = word_idx_reg + COUNT_BITS'(1);
                        end
                        else
                        begin
                            plane_next   = plane_upd;
                            bit_idx_next = bit_idx_reg + BIT_W'(1);
                        end
                    end
                end
                default:
                begin
                    mode_next = mode_dec;
                end
            endcase
        end
    end

    // Job outputs.
    always_comb
    begin
        job      = '0;
        job.kind = fotb_pkg::KIND_RECORD;
        push     = 1'b0;
        case (act)
            ACT_NAME:
            begin
                push          = 1'b1;
                job.kind      = fotb_pkg::KIND_NAME;
                job.name_byte = text_byte;
            end
            ACT_HEADER:
            begin
                push         = 1'b1;
                job.kind     = fotb_pkg::KIND_RECORD;
                job.position = count_pos;
            end
            ACT_BASE:
            begin
                if (take_err)
                begin
                    push         = 1'b1;
                    job.kind     = fotb_pkg::KIND_ERROR;
                    job.position = count_pos;
                end
                else if (word_done)
                begin
                    push         = 1'b1;
                    job.kind     = fotb_pkg::KIND_PLANE;
                    job.position = word_pos;
                    job.planes   = plane_upd_ext;
                end
            end
            ACT_EOF:
            begin
                push = 1'b1;
                if (error_reg)
                begin
                    job.kind     = fotb_pkg::KIND_ERROR;
                    job.position = count_pos;
                end
                else if (bit_idx_reg != '0)
                begin
                    job.kind      = fotb_pkg::KIND_PLANE;
                    job.position  = word_pos;
                    job.planes    = plane_reg_ext;
                    job.has_total = 1'b1;
                    job.total_pos = count_pos;
                end
                else
                begin
                    job.kind     = fotb_pkg::KIND_TOTAL;
                    job.position = count_pos;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
        push = push & accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= fotb_pkg::MODE_START;
            record_open_reg <= 1'b0;
            error_reg       <= 1'b0;
            count_reg       <= '0;
            word_idx_reg    <= '0;
            bit_idx_reg     <= '0;
            plane_reg       <= '0;
        end
        else
        begin
            mode_reg        <= mode_next;
            record_open_reg <= record_open_next;
            error_reg       <= error_next;
            count_reg       <= count_next;
            word_idx_reg    <= word_idx_next;
            bit_idx_reg     <= bit_idx_next;
            plane_reg       <= plane_next;
        end
    end

endmodule

[rtl/core/fotb_queue.sv]
// Short job queue between the front end and the result emitter.
module fotb_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fotb_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output fotb_pkg::job_t  head,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    fotb_pkg::job_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[rtl/core/fotb_back.sv]
// Back end: expands queued jobs into result items and holds the output register.
module fotb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  fotb_pkg::job_t      head,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output fotb_pkg::result_t   result
);

    logic out_valid_reg, out_valid_next;
    logic pend_reg, pend_next;
    logic [fotb_pkg::POS_BITS-1:0] total_pos_reg, total_pos_next;
    fotb_pkg::result_t result_reg, result_next;
    logic load;

    assign load = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        total_pos_next = total_pos_reg;
        result_next    = result_reg;
        pop            = 1'b0;
        if (load)
        begin
            if (pend_reg)
            begin
                // Second half of an end-of-file job: the base total.
                out_valid_next       = 1'b1;
                pend_next            = 1'b0;
                result_next          = '0;
                result_next.kind     = fotb_pkg::KIND_TOTAL;
                result_next.position = total_pos_reg;
                result_next.last     = 1'b1;
            end
            else if (!empty)
            begin
                pop                   = 1'b1;
                out_valid_next        = 1'b1;
                pend_next             = head.has_total;
                total_pos_next        = head.total_pos;
                result_next.kind      = head.kind;
                result_next.position  = head.position;
                result_next.name_byte = head.name_byte;
                result_next.planes    = head.planes;
                result_next.last      = !head.has_total;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_pos_reg <= total_pos_next;
        result_reg    <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

[rtl/core/fasta_to_onehot_bitplanes_unit.sv]
// Top level of the FASTA parser that packs bases into one-hot bitplane words.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_ready  | text_byte, end_of_file
//  out     | out_valid / out_ready| kind, position, name_byte, plane_a..plane_t, last
//
// One input transfer is taken per cycle while in_ready is high; the parser state
// updates in that same cycle. Each input causes zero, one or two result transfers;
// only end of file causes two, so the output side drains at one result per cycle
// while out_ready is high and the job queue absorbs the extra. An input's first
// result passes through the job queue and then the output register. in_ready falls
// only while the job queue is full. That happens under output stalls, and after
// an end-of-file flush sending both a word and the total under back-to-back input.
// rst_n clears the line mode, record and error flags, base count and plane bits.
//
// The front end sorts each line by its first byte (header, comment, sequence or
// skipped), keeps the running base count split into a word index and a bit index,
// and ORs each base into its plane. A finished word, a name byte, a record start, an
// error or an end-of-file flush becomes one job in a short queue. The back end turns
// each job into result transfers; an end-of-file flush with a partial word yields the
// word and then the total. An invalid base or a full base count is an error reported
// at once; later bytes are dropped until end of file, which reports the error again.
module fasta_to_onehot_bitplanes_unit #(
    parameter int WORD_BASES = 64,
    parameter int COUNT_BITS = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [39:0] position,
    output logic [7:0]  name_byte,
    output logic [63:0] plane_a,
    output logic [63:0] plane_c,
    output logic [63:0] plane_g,
    output logic [63:0] plane_t,
    output logic        last
);

    fotb_pkg::job_t    push_job;
    fotb_pkg::job_t    head;
    fotb_pkg::result_t result;
    logic full;
    logic empty;
    logic push;
    logic pop;
    logic accept;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    fotb_front #(
        .WORD_BASES (WORD_BASES),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text_byte),
        .end_of_file (end_of_file),
        .push        (push),
        .job         (push_job)
    );

    fotb_queue #(
        .DEPTH (fotb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    fotb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    // Plane order in the job and result records is A, C, G, T from bit 0 up.
    assign kind      = result.kind;
    assign position  = result.position;
    assign name_byte = result.name_byte;
    assign plane_a   = result.planes[0];
    assign plane_c   = result.planes[1];
    assign plane_g   = result.planes[2];
    assign plane_t   = result.planes[3];
    assign last      = result.last;

endmodule

[rtl/core/fotb_checker.sv]
// Port-level checks of the FASTA bitplane parser, bound to its top level.
module fotb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [7:0]  name_byte,
    input logic [63:0] plane_a,
    input logic [63:0] plane_c,
    input logic [63:0] plane_g,
    input logic [63:0] plane_t,
    input logic        last
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Only a flushed plane word is followed by another result of the same input.
    a_not_last_is_plane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> kind == fotb_pkg::KIND_PLANE)
        else $error("non-final result is not a plane word");

    // The total follows the flushed word in the very next cycle.
    a_total_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && last
            && kind == fotb_pkg::KIND_TOTAL)
        else $error("total missing after flushed word");

    // Name results carry no plane bits.
    a_name_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == fotb_pkg::KIND_NAME |->
            last && plane_a == '0 && plane_c == '0 && plane_g == '0 && plane_t == '0)
        else $error("name result carries plane bits");

    // Only name results carry a name byte.
    a_name_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != fotb_pkg::KIND_NAME |-> name_byte == 8'h00)
        else $error("name byte set on a non-name result");

endmodule

bind fasta_to_onehot_bitplanes_unit fotb_checker u_fotb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .name_byte (name_byte),
    .plane_a   (plane_a),
    .plane_c   (plane_c),
    .plane_g   (plane_g),
    .plane_t   (plane_t),
    .last      (last)
);
